// ===== design/b58d_pkg.sv =====
package b58d_pkg;

    localparam int unsigned SymbolWidth = 8;
    localparam int unsigned DigitWidth  = 6;
    localparam int unsigned ValueWidth  = 32;
    localparam int unsigned StatusWidth = 2;
    localparam int unsigned Base        = 58;

    // Result status codes
    typedef enum logic [StatusWidth-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef struct packed {
        logic [SymbolWidth-1:0] symbol;
        logic                   has_symbol;
        logic                   last;
    } t_in_item;

    typedef struct packed {
        logic [ValueWidth-1:0] value;
        t_status               status;
    } t_out_item;

    typedef struct packed {
        logic                  ok;
        logic [DigitWidth-1:0] digit;
    } t_digit;

    // Map one character to its digit; alphabet is digits 1-9, lower case
    // (no 'l'), then upper case (no 'I' or 'O').
    function automatic t_digit digit_of(input logic [SymbolWidth-1:0] c);
        t_digit d;
        d.ok    = 1'b1;
        d.digit = '0;
        case (c) inside
            [8'h31:8'h39]: d.digit = DigitWidth'(c - 8'h31);          // '1'..'9'
            [8'h61:8'h6B]: d.digit = DigitWidth'(c - 8'h61 + 8'd9);   // 'a'..'k'
            [8'h6D:8'h7A]: d.digit = DigitWidth'(c - 8'h6D + 8'd20);  // 'm'..'z'
            [8'h41:8'h48]: d.digit = DigitWidth'(c - 8'h41 + 8'd34);  // 'A'..'H'
            [8'h4A:8'h4E]: d.digit = DigitWidth'(c - 8'h4A + 8'd42);  // 'J'..'N'
            [8'h50:8'h5A]: d.digit = DigitWidth'(c - 8'h50 + 8'd47);  // 'P'..'Z'
            default:       d.ok    = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ===== design/base58_decode_uint32.sv =====
// Streaming base58 to 32-bit unsigned decoder. One character arrives per
// item, most significant first, and one item is taken every cycle unless
// a last item waits for a full result register: each character goes
// through an input register, then one multiply-by-58-and-add into the
// accumulator; a last item loads its result register. Only the last item
// of a string produces a result (value and status); its status is range
// if the part after the final bad character exceeds 2^32-1, else invalid
// for a bad character or an empty string, else ok. Value is zero unless
// ok. An item with no character and not last is consumed without effect.
module base58_decode_uint32
    import b58d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int unsigned ProdWidth = ValueWidth + DigitWidth;

    logic                  r_in_valid;
    t_in_item              r_in;
    logic [ValueWidth-1:0] r_acc;
    logic                  r_ovf;
    logic                  r_inv;
    logic                  r_seen;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [ValueWidth-1:0] n_acc;
    logic                  n_ovf;
    logic                  n_inv;
    logic                  n_seen;
    t_out_item             n_out;

    t_digit                dig;
    logic [ProdWidth-1:0]  prod;
    logic                  slot_free;
    logic                  adv;

    // Stage 1 moves when its item needs no result slot or one is free
    assign slot_free  = !r_out_valid || i_out_ready;
    assign adv        = r_in_valid && (!r_in.last || slot_free);
    assign o_in_ready = !r_in_valid || adv;

    // Decode and accumulate the registered character
    assign dig  = digit_of(r_in.symbol);
    assign prod = ProdWidth'(r_acc) * ProdWidth'(Base) + ProdWidth'(dig.digit);

    always_comb begin
        n_acc  = r_acc;
        n_ovf  = r_ovf;
        n_inv  = r_inv;
        n_seen = r_seen;
        if (r_in.has_symbol) begin
            n_seen = 1'b1;
            if (!dig.ok) begin
                // bad character: restart range check on the suffix
                n_inv = 1'b1;
                n_acc = '0;
                n_ovf = 1'b0;
            end else if (!r_ovf) begin
                if (prod[ProdWidth-1:ValueWidth] != '0) begin
                    n_ovf = 1'b1;
                    n_acc = '1;
                end else begin
                    n_acc = prod[ValueWidth-1:0];
                end
            end
        end
    end

    // Build the result for a last item
    always_comb begin
        n_out.value  = '0;
        n_out.status = ST_OK;
        if (n_ovf) begin
            n_out.status = ST_RANGE;
        end else if (n_inv || !n_seen) begin
            n_out.status = ST_INVALID;
        end else begin
            n_out.value = n_acc;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Decoder state: advance per item, clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_ovf  <= 1'b0;
            r_inv  <= 1'b0;
            r_seen <= 1'b0;
        end else if (adv) begin
            if (r_in.last) begin
                r_acc  <= '0;
                r_ovf  <= 1'b0;
                r_inv  <= 1'b0;
                r_seen <= 1'b0;
            end else begin
                r_acc  <= n_acc;
                r_ovf  <= n_ovf;
                r_inv  <= n_inv;
                r_seen <= n_seen;
            end
        end
    end

    // Result register: load on a last item, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv && r_in.last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Value is zero on any error status
    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> (r_out.value == '0))
        else $error("nonzero value with error status");

    // Overflow saturates the accumulator
    a_ovf_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_acc == '1))
        else $error("overflow without saturated accumulator");

    // State returns to reset after the last item of a string
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.last) |=> (r_acc == '0 && !r_ovf && !r_inv && !r_seen))
        else $error("state not cleared after last item");

    // A last item always lands in the result register
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.last) |=> r_out_valid)
        else $error("last item produced no result");

endmodule
